>>> rtl/wsd_pkg.sv
// ----------------------------------------------------------------------------
// wsd_pkg: shared types and constants of the WebSocket frame deframer
// Holds the parse phase encoding, the frame action codes, the result record
// passed from the parser to the output stage, and the opcode decode.
// ----------------------------------------------------------------------------
package wsd_pkg;

    localparam int LENGTH_WIDTH_DEFAULT = 64;

    // Header bit positions and field masks.
    localparam int  FIN_BIT    = 7;
    localparam int  MASK_BIT   = 7;
    localparam logic [6:0] LEN_CODE_16 = 7'd126;
    localparam logic [6:0] LEN_CODE_64 = 7'd127;

    // Header byte counts that open and close the extended length fields.
    localparam logic [3:0] HDR_LAST_LEN16 = 4'd3;
    localparam logic [3:0] HDR_LAST_LEN64 = 4'd9;
    localparam logic [3:0] HDR_FIRST_EXT  = 4'd2;

    localparam logic [3:0] OP_CONT   = 4'h0;
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;
    localparam logic [3:0] OP_PONG   = 4'ha;

    typedef enum logic [3:0] {
        PH_HDR0    = 4'd0,
        PH_HDR1    = 4'd1,
        PH_LEN16   = 4'd2,
        PH_LEN64   = 4'd3,
        PH_KEY0    = 4'd4,
        PH_KEY1    = 4'd5,
        PH_KEY2    = 4'd6,
        PH_KEY3    = 4'd7,
        PH_PAYLOAD = 4'd8
    } phase_t;

    typedef enum logic [2:0] {
        ACT_DELIVER = 3'd0,
        ACT_DROP    = 3'd1,
        ACT_CLOSE   = 3'd2,
        ACT_PONG    = 3'd3,
        ACT_PONG_SEEN = 3'd4,
        ACT_INVALID = 3'd5
    } action_t;

    typedef struct packed {
        logic       has_data;
        logic [7:0] payload_byte;
        logic       frame_end;
        logic [3:0] frame_opcode;
        logic       frame_fin;
        action_t    frame_action;
        logic       protocol_error;
    } result_t;

    function automatic action_t action_of(input logic [3:0] op);
        action_t act;
        case (op)
            OP_CONT, OP_TEXT: act = ACT_DELIVER;
            OP_BINARY:        act = ACT_DROP;
            OP_CLOSE:         act = ACT_CLOSE;
            OP_PING:          act = ACT_PONG;
            OP_PONG:          act = ACT_PONG_SEEN;
            default:          act = ACT_INVALID;
        endcase
        return act;
    endfunction

endpackage

>>> rtl/wsd_parser.sv
// ----------------------------------------------------------------------------
// wsd_parser: frame header parser and payload unmasker
// Keeps the per-frame header state, updates it on every accepted beat and
// forms at most one result per beat for the output stage.
// ----------------------------------------------------------------------------
module wsd_parser #(
    parameter int LENGTH_WIDTH = wsd_pkg::LENGTH_WIDTH_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [7:0]       data_byte,
    input  logic             packet_end,
    output logic             res_valid,
    output wsd_pkg::result_t res
);

    wsd_pkg::phase_t          phase_reg, phase_next;
    logic                     fin_reg, fin_next;
    logic [3:0]               opcode_reg, opcode_next;
    logic [3:0]               header_count_reg, header_count_next;
    logic [LENGTH_WIDTH-1:0]  payload_length_reg, payload_length_next;
    logic [31:0]              mask_key_reg, mask_key_next;
    logic [LENGTH_WIDTH-1:0]  received_count_reg, received_count_next;
    logic                     discarding_reg, discarding_next;

    logic [LENGTH_WIDTH-1:0]  count_inc;
    logic [LENGTH_WIDTH-1:0]  length_shifted;
    logic [7:0]               key_byte;
    logic [3:0]               header_inc;

    assign count_inc  = received_count_reg + LENGTH_WIDTH'(1);
    assign header_inc = header_count_reg + 4'd1;

    // A length that would overflow the counter width saturates to all ones.
    assign length_shifted = (payload_length_reg[LENGTH_WIDTH-1 -: 8] != 8'd0)
                          ? '1
                          : {payload_length_reg[LENGTH_WIDTH-9:0], data_byte};

    always_comb
    begin
        case (received_count_reg[1:0])
            2'd0:    key_byte = mask_key_reg[31:24];
            2'd1:    key_byte = mask_key_reg[23:16];
            2'd2:    key_byte = mask_key_reg[15:8];
            default: key_byte = mask_key_reg[7:0];
        endcase
    end

    always_comb
    begin
        phase_next          = phase_reg;
        fin_next            = fin_reg;
        opcode_next         = opcode_reg;
        header_count_next   = header_count_reg;
        payload_length_next = payload_length_reg;
        mask_key_next       = mask_key_reg;
        received_count_next = received_count_reg;
        discarding_next     = discarding_reg;

        res_valid          = 1'b0;
        res.has_data       = 1'b0;
        res.payload_byte   = 8'd0;
        res.frame_end      = 1'b0;
        res.frame_opcode   = opcode_reg;
        res.frame_fin      = fin_reg;
        res.frame_action   = wsd_pkg::ACT_DELIVER;
        res.protocol_error = 1'b0;

        if (!accept)
        begin
            // Hold state.
        end
        else if (discarding_reg)
        begin
            if (packet_end)
            begin
                discarding_next = 1'b0;
            end
        end
        else
        begin
            case (phase_reg)
                wsd_pkg::PH_HDR0:
                begin
                    fin_next          = data_byte[wsd_pkg::FIN_BIT];
                    opcode_next       = data_byte[3:0];
                    header_count_next = 4'd1;
                    phase_next        = wsd_pkg::PH_HDR1;
                end
                wsd_pkg::PH_HDR1:
                begin
                    if (!data_byte[wsd_pkg::MASK_BIT])
                    begin
                        // Client frames must be masked: flag it and skip the
                        // rest of the packet.
                        res_valid          = 1'b1;
                        res.protocol_error = 1'b1;
                        phase_next         = wsd_pkg::PH_HDR0;
                        fin_next           = 1'b0;
                        opcode_next        = 4'd0;
                        header_count_next  = 4'd0;
                        discarding_next    = !packet_end;
                    end
                    else
                    begin
                        payload_length_next = {{(LENGTH_WIDTH-7){1'b0}}, data_byte[6:0]};
                        if (data_byte[6:0] == wsd_pkg::LEN_CODE_16)
                            phase_next = wsd_pkg::PH_LEN16;
                        else if (data_byte[6:0] == wsd_pkg::LEN_CODE_64)
                            phase_next = wsd_pkg::PH_LEN64;
                        else
                            phase_next = wsd_pkg::PH_KEY0;
                        header_count_next = header_inc;
                    end
                end
                wsd_pkg::PH_LEN16, wsd_pkg::PH_LEN64:
                begin
                    if (header_count_reg == wsd_pkg::HDR_FIRST_EXT)
                        payload_length_next = {{(LENGTH_WIDTH-8){1'b0}}, data_byte};
                    else
                        payload_length_next = length_shifted;
                    if ((phase_reg == wsd_pkg::PH_LEN16
                            && header_count_reg >= wsd_pkg::HDR_LAST_LEN16)
                        || (phase_reg == wsd_pkg::PH_LEN64
                            && header_count_reg >= wsd_pkg::HDR_LAST_LEN64))
                        phase_next = wsd_pkg::PH_KEY0;
                    header_count_next = header_inc;
                end
                wsd_pkg::PH_KEY0:
                begin
                    mask_key_next     = {mask_key_reg[23:0], data_byte};
                    phase_next        = wsd_pkg::PH_KEY1;
                    header_count_next = header_inc;
                end
                wsd_pkg::PH_KEY1:
                begin
                    mask_key_next     = {mask_key_reg[23:0], data_byte};
                    phase_next        = wsd_pkg::PH_KEY2;
                    header_count_next = header_inc;
                end
                wsd_pkg::PH_KEY2:
                begin
                    mask_key_next     = {mask_key_reg[23:0], data_byte};
                    phase_next        = wsd_pkg::PH_KEY3;
                    header_count_next = header_inc;
                end
                wsd_pkg::PH_KEY3:
                begin
                    mask_key_next       = {mask_key_reg[23:0], data_byte};
                    header_count_next   = header_inc;
                    received_count_next = '0;
                    if (payload_length_reg != '0)
                    begin
                        phase_next = wsd_pkg::PH_PAYLOAD;
                    end
                    else
                    begin
                        // An empty frame completes on its last key byte.
                        res_valid          = 1'b1;
                        res.frame_end      = 1'b1;
                        res.frame_action   = wsd_pkg::action_of(opcode_reg);
                        phase_next         = wsd_pkg::PH_HDR0;
                        fin_next           = 1'b0;
                        opcode_next        = 4'd0;
                        header_count_next  = 4'd0;
                    end
                end
                wsd_pkg::PH_PAYLOAD:
                begin
                    res_valid           = 1'b1;
                    res.has_data        = 1'b1;
                    res.payload_byte    = data_byte ^ key_byte;
                    received_count_next = count_inc;
                    if (count_inc == payload_length_reg)
                    begin
                        res.frame_end     = 1'b1;
                        res.frame_action  = wsd_pkg::action_of(opcode_reg);
                        phase_next        = wsd_pkg::PH_HDR0;
                        fin_next          = 1'b0;
                        opcode_next       = 4'd0;
                        header_count_next = 4'd0;
                    end
                end
                default:
                begin
                    phase_next = wsd_pkg::PH_HDR0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= wsd_pkg::PH_HDR0;
            fin_reg            <= 1'b0;
            opcode_reg         <= 4'd0;
            header_count_reg   <= 4'd0;
            payload_length_reg <= '0;
            mask_key_reg       <= 32'd0;
            received_count_reg <= '0;
            discarding_reg     <= 1'b0;
        end
        else
        begin
            phase_reg          <= phase_next;
            fin_reg            <= fin_next;
            opcode_reg         <= opcode_next;
            header_count_reg   <= header_count_next;
            payload_length_reg <= payload_length_next;
            mask_key_reg       <= mask_key_next;
            received_count_reg <= received_count_next;
            discarding_reg     <= discarding_next;
        end
    end

`ifndef SYNTHESIS
    a_error_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.protocol_error) |-> (!res.has_data && !res.frame_end))
        else $error("protocol error result carries data or frame end");

    a_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.frame_end) |=> (phase_reg == wsd_pkg::PH_HDR0))
        else $error("parser did not return to header after frame end");

    a_unmasked_discards: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !discarding_reg && phase_reg == wsd_pkg::PH_HDR1
            && !data_byte[wsd_pkg::MASK_BIT] && !packet_end) |=> discarding_reg)
        else $error("unmasked frame did not start discarding");

    a_discard_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        discarding_reg |-> !res_valid)
        else $error("result produced while discarding");

    a_packet_end_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && discarding_reg && packet_end) |=> !discarding_reg)
        else $error("discarding did not end at packet end");
`endif

endmodule

>>> rtl/wsd_out_stage.sv
// ----------------------------------------------------------------------------
// wsd_out_stage: result register
// Holds one finished result until the downstream side takes it, and lets a
// new beat in whenever the register is empty or being emptied.
// ----------------------------------------------------------------------------
module wsd_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             accept,
    input  logic             res_valid,
    input  wsd_pkg::result_t res,
    output logic             out_valid,
    input  logic             out_ready,
    output wsd_pkg::result_t out_res
);

    logic             valid_reg, valid_next;
    wsd_pkg::result_t res_reg;

    assign in_ready = !valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        if (accept)
            valid_next = res_valid;
        else if (out_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && res_valid)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

>>> rtl/websocket_frame_deframer_unit.sv
// ----------------------------------------------------------------------------
// websocket_frame_deframer_unit: WebSocket client frame deframer
// Parses client frame headers from a byte stream and emits unmasked payload.
// ----------------------------------------------------------------------------
// The block takes one stream byte per beat and can accept a beat in every
// clock cycle unless stalled; each byte passes through the header parser, and
// its result is captured in a single result register and appears on the output
// the cycle after its byte is accepted. Header, length and mask-key bytes
// give no result. Each payload byte gives one result with the unmasked byte;
// the last one also carries frame_end and the opcode's action. An empty frame
// ends with a data-less result on its last mask-key byte. A frame without the
// mask bit gives one protocol_error result, and the rest of its packet (up to
// the byte with packet_end set) is dropped. Lengths above LENGTH_WIDTH bits
// saturate. Input is stalled only while a result waits for out_ready.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_unit #(
    parameter int LENGTH_WIDTH = wsd_pkg::LENGTH_WIDTH_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       packet_end,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       has_data,
    output logic [7:0] payload_byte,
    output logic       frame_end,
    output logic [3:0] frame_opcode,
    output logic       frame_fin,
    output logic [2:0] frame_action,
    output logic       protocol_error
);

    logic             accept;
    logic             res_valid;
    wsd_pkg::result_t res;
    wsd_pkg::result_t out_res;

    wsd_parser #(
        .LENGTH_WIDTH(LENGTH_WIDTH)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (data_byte),
        .packet_end(packet_end),
        .res_valid (res_valid),
        .res       (res)
    );

    wsd_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .accept   (accept),
        .res_valid(res_valid),
        .res      (res),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_res  (out_res)
    );

    assign has_data       = out_res.has_data;
    assign payload_byte   = out_res.payload_byte;
    assign frame_end      = out_res.frame_end;
    assign frame_opcode   = out_res.frame_opcode;
    assign frame_fin      = out_res.frame_fin;
    assign frame_action   = out_res.frame_action;
    assign protocol_error = out_res.protocol_error;

endmodule
